// ===== hw/rtl/bbp_pkg.sv =====
// Shared types and constants of the burst bit-to-byte packer.
package bbp_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	// job fields sized for vector lengths of up to 64 bytes
	localparam int JOB_CNT_W = 7;
	localparam int JOB_IDX_W = 6;

	localparam int Q_DEPTH = 2;

	typedef enum logic [1:0] {
		CFG_BIT_ORDER  = 2'd0,
		CFG_TAIL_MODE  = 2'd1,
		CFG_VECTOR_LEN = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		TAIL_DROP      = 2'd0,
		TAIL_PAD_RIGHT = 2'd1,
		TAIL_PAD_FRONT = 2'd2,
		TAIL_PAD_SPARE = 2'd3
	} tail_mode_t;

	typedef struct packed {
		logic       lsb_order;
		logic [1:0] tail_mode;
		logic [4:0] vector_len;
	} cfg_t;

	typedef struct packed {
		logic                 store_en;
		logic [JOB_IDX_W-1:0] store_idx;
		logic [7:0]           data;
		logic [JOB_CNT_W-1:0] flush_n;
		logic                 direct;
		logic                 direct_vend;
		logic [JOB_CNT_W-1:0] fill_n;
	} job_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_READ,
		B_FLUSH,
		B_DIRECT,
		B_FILL
	} back_state_t;

endpackage

// ===== hw/rtl/burst_bit_to_byte_packer_core.sv =====
// Top level of the burst bit-to-byte packer: configuration registers, front, queue, back.
// Takes one bit per transfer and packs bits into bytes (MSB- or LSB-first), grouped into vectors
// of vector_len bytes. In drop mode bytes are held until a vector is full and the stub at burst
// end is discarded; in the pad modes each byte goes out at once and a burst end pads the partial
// byte and fills the vector with zero bytes. The front end takes one bit per cycle as long as its
// two-entry job queue has room; a job is issued only when a byte completes or a padded burst ends,
// so at most one job per eight bits in steady streaming. The back end takes a job while idle; a
// byte from hold memory goes via a registered read to the output register; direct and zero-fill
// bytes go straight to it. The user must write configuration only while idle (not enforced).
module burst_bit_to_byte_packer_core #(
	parameter int MAX_VECTOR_BYTES = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bbp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bbp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  logic                           bit_in,
	input  logic                           burst_end,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic [7:0]                     data_byte,
	output logic                           vector_end,
	output logic                           run_last
);

	bbp_pkg::cfg_t        cfg_q;
	bbp_pkg::job_t        push_job;
	bbp_pkg::job_t        q_head;
	bbp_pkg::back_state_t bst;
	logic                 q_push;
	logic                 q_pop;
	logic                 q_full;
	logic                 q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lsb_order  <= 1'b0;
			cfg_q.tail_mode  <= bbp_pkg::TAIL_DROP;
			cfg_q.vector_len <= 5'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				bbp_pkg::CFG_BIT_ORDER:  cfg_q.lsb_order  <= cfg_data[0];
				bbp_pkg::CFG_TAIL_MODE:  cfg_q.tail_mode  <= cfg_data[1:0];
				bbp_pkg::CFG_VECTOR_LEN: cfg_q.vector_len <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	bbp_front #(
		.MAX_VECTOR_BYTES(MAX_VECTOR_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.bit_in     (bit_in),
		.burst_end  (burst_end),
		.q_full     (q_full),
		.push       (q_push),
		.job        (push_job)
	);

	bbp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_job (push_job),
		.pop    (q_pop),
		.head   (q_head),
		.full   (q_full),
		.empty  (q_empty)
	);

	bbp_back #(
		.MAX_VECTOR_BYTES(MAX_VECTOR_BYTES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.data_byte    (data_byte),
		.vector_end   (vector_end),
		.run_last     (run_last),
		.state        (bst)
	);

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("job taken from empty queue");

	a_read_then_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(bst == bbp_pkg::B_READ) |=> (bst == bbp_pkg::B_FLUSH))
		else $error("hold read not followed by flush");

	a_idle_no_new_result: assert property (@(posedge clk) disable iff (!arst_n)
		(bst == bbp_pkg::B_IDLE && !result_valid) |=> !result_valid)
		else $error("result produced from idle back end");

endmodule

// ===== hw/rtl/bbp_front.sv =====
// Front end: accepts bits, packs bytes, tracks vector position and issues jobs.
module bbp_front #(
	parameter int MAX_VECTOR_BYTES = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  bbp_pkg::cfg_t cfg,
	input  logic          item_valid,
	output logic          item_stall,
	input  logic          bit_in,
	input  logic          burst_end,
	input  logic          q_full,
	output logic          push,
	output bbp_pkg::job_t job
);

	localparam int CNT_W = $clog2(MAX_VECTOR_BYTES + 1);
	localparam int LW    = (CNT_W > 5) ? CNT_W : 5;
	localparam int JCW   = bbp_pkg::JOB_CNT_W;
	localparam int JIW   = bbp_pkg::JOB_IDX_W;

	logic [7:0]       shift_q;
	logic [2:0]       bits_q;
	logic [CNT_W-1:0] vbc_q;

	logic             accept;
	logic             drop;
	logic             zero_front;
	logic [LW-1:0]    vl_ext;
	logic [CNT_W-1:0] len;
	logic [7:0]       sb_new;
	logic [2:0]       bc_new;
	logic             complete;
	logic [2:0]       pad_amt;
	logic [7:0]       padded;
	logic [CNT_W-1:0] cnt_inc;
	logic             full;
	logic [CNT_W-1:0] vbc_mid;
	logic [CNT_W-1:0] vbc_d;
	logic             job_valid;

	always_comb begin
		accept     = item_valid & ~q_full;
		item_stall = q_full;
		drop       = (cfg.tail_mode == bbp_pkg::TAIL_DROP);
		zero_front = (cfg.tail_mode == bbp_pkg::TAIL_PAD_FRONT);

		vl_ext = LW'(cfg.vector_len);
		if (vl_ext == '0) begin
			len = CNT_W'(1);
		end else if (vl_ext > LW'(MAX_VECTOR_BYTES)) begin
			len = CNT_W'(MAX_VECTOR_BYTES);
		end else begin
			len = CNT_W'(vl_ext);
		end

		sb_new   = cfg.lsb_order ? {bit_in, shift_q[7:1]} : {shift_q[6:0], bit_in};
		bc_new   = bits_q + 3'd1;
		complete = (bc_new == 3'd0);
		pad_amt  = 3'(4'd8 - {1'b0, bc_new});
		if (zero_front) begin
			padded = sb_new;
		end else if (cfg.lsb_order) begin
			padded = sb_new >> pad_amt;
		end else begin
			padded = sb_new << pad_amt;
		end

		cnt_inc   = vbc_q + CNT_W'(1);
		full      = (cnt_inc >= len);
		vbc_mid   = full ? '0 : cnt_inc;
		vbc_d     = vbc_q;
		job       = '0;
		job_valid = 1'b0;

		if (drop) begin
			if (complete) begin
				job_valid     = 1'b1;
				job.store_en  = 1'b1;
				job.store_idx = JIW'(vbc_q);
				job.data      = sb_new;
				if (full) begin
					job.flush_n = JCW'(cnt_inc);
				end
				vbc_d = vbc_mid;
			end
			if (burst_end) begin
				vbc_d = '0;
			end
		end else if (complete || burst_end) begin
			job_valid       = 1'b1;
			job.direct      = 1'b1;
			job.data        = complete ? sb_new : padded;
			job.direct_vend = full;
			vbc_d           = vbc_mid;
			if (burst_end) begin
				if (vbc_mid != '0) begin
					job.fill_n = JCW'(len - vbc_mid);
				end
				vbc_d = '0;
			end
		end

		push = accept & job_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
			bits_q  <= '0;
			vbc_q   <= '0;
		end else if (accept) begin
			shift_q <= (complete || burst_end) ? 8'h00 : sb_new;
			bits_q  <= burst_end ? 3'd0 : bc_new;
			vbc_q   <= vbc_d;
		end
	end

endmodule

// ===== hw/rtl/bbp_queue.sv =====
// Two-entry job queue between the front end and the back end.
module bbp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bbp_pkg::job_t wr_job,
	input  logic          pop,
	output bbp_pkg::job_t head,
	output logic          full,
	output logic          empty
);

	localparam int PW = $clog2(bbp_pkg::Q_DEPTH);
	localparam int CW = $clog2(bbp_pkg::Q_DEPTH + 1);

	bbp_pkg::job_t ent_q [bbp_pkg::Q_DEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(bbp_pkg::Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + PW'(1);
			end
			if (pop) begin
				rp_q <= rp_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= wr_job;
		end
	end

endmodule

// ===== hw/rtl/bbp_back.sv =====
// Back end: holds vector bytes, expands jobs into output bytes, drives the output register.
module bbp_back #(
	parameter int MAX_VECTOR_BYTES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  bbp_pkg::job_t        q_head,
	output logic                 q_pop,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic [7:0]           data_byte,
	output logic                 vector_end,
	output logic                 run_last,
	output bbp_pkg::back_state_t state
);

	localparam int CNT_W = $clog2(MAX_VECTOR_BYTES + 1);
	localparam int IDX_W = (MAX_VECTOR_BYTES > 1) ? $clog2(MAX_VECTOR_BYTES) : 1;

	logic [7:0] hold_q [MAX_VECTOR_BYTES];

	bbp_pkg::back_state_t st_q;
	bbp_pkg::back_state_t st_d;
	bbp_pkg::job_t        job_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     cnt_d;
	logic [7:0]           rd_q;
	logic                 out_valid_q;
	logic [7:0]           byte_q;
	logic                 vend_q;
	logic                 last_q;

	logic             free;
	logic [CNT_W-1:0] flush_n;
	logic [CNT_W-1:0] fill_n;
	logic [CNT_W-1:0] cnt_nx;
	logic             load;
	logic             rd_en;
	logic [7:0]       ld_byte;
	logic             ld_vend;
	logic             ld_last;

	always_comb begin
		free    = ~out_valid_q | ~result_stall;
		flush_n = CNT_W'(job_q.flush_n);
		fill_n  = CNT_W'(job_q.fill_n);
		cnt_nx  = cnt_q + CNT_W'(1);
		st_d    = st_q;
		cnt_d   = cnt_q;
		q_pop   = 1'b0;
		load    = 1'b0;
		rd_en   = 1'b0;
		ld_byte = 8'h00;
		ld_vend = 1'b0;
		ld_last = 1'b0;
		case (st_q)
			bbp_pkg::B_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					cnt_d = '0;
					if (q_head.flush_n != '0) begin
						st_d = bbp_pkg::B_READ;
					end else if (q_head.direct) begin
						st_d = bbp_pkg::B_DIRECT;
					end
				end
			end
			bbp_pkg::B_READ: begin
				rd_en = 1'b1;
				st_d  = bbp_pkg::B_FLUSH;
			end
			bbp_pkg::B_FLUSH: begin
				if (free) begin
					load    = 1'b1;
					ld_byte = rd_q;
					ld_vend = (cnt_nx == flush_n);
					ld_last = ld_vend;
					cnt_d   = cnt_nx;
					st_d    = ld_vend ? bbp_pkg::B_IDLE : bbp_pkg::B_READ;
				end
			end
			bbp_pkg::B_DIRECT: begin
				if (free) begin
					load    = 1'b1;
					ld_byte = job_q.data;
					ld_vend = job_q.direct_vend;
					ld_last = (job_q.fill_n == '0);
					cnt_d   = '0;
					st_d    = ld_last ? bbp_pkg::B_IDLE : bbp_pkg::B_FILL;
				end
			end
			bbp_pkg::B_FILL: begin
				if (free) begin
					load    = 1'b1;
					ld_byte = 8'h00;
					ld_vend = (cnt_nx == fill_n);
					ld_last = ld_vend;
					cnt_d   = cnt_nx;
					st_d    = ld_vend ? bbp_pkg::B_IDLE : bbp_pkg::B_FILL;
				end
			end
			default: begin
				st_d = bbp_pkg::B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= bbp_pkg::B_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q  <= st_d;
			cnt_q <= cnt_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_head;
		end
		if (load) begin
			byte_q <= ld_byte;
			vend_q <= ld_vend;
			last_q <= ld_last;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_head.store_en) begin
			hold_q[IDX_W'(q_head.store_idx)] <= q_head.data;
		end
		if (rd_en) begin
			rd_q <= hold_q[cnt_q[IDX_W-1:0]];
		end
	end

	assign result_valid = out_valid_q;
	assign data_byte    = byte_q;
	assign vector_end   = vend_q;
	assign run_last     = last_q;
	assign state        = st_q;

endmodule
